// ----- rtl/vam_pkg.sv -----
// Shared types, codes and the reciprocal table of the adjacency Laplacian builder.
package vam_pkg;

    localparam int IDX_W = 6;   // vertex index fields
    localparam int CNT_W = 7;   // vertex_count register
    localparam int WGT_W = 17;  // Q1.16 weight
    localparam int STS_W = 2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    localparam logic [STS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STS_W-1:0] ST_INDEX_ERR = 2'd1;
    localparam logic [STS_W-1:0] ST_ROW_RANGE = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_WR    = 7'b0000100,
        S_ROWRD = 7'b0001000,
        S_ROWLD = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    // row being updated and the two other corners of the triangle
    typedef struct packed {
        logic [IDX_W-1:0] self_idx;
        logic [IDX_W-1:0] peer_p;
        logic [IDX_W-1:0] peer_q;
    } corner_sel_t;

    // round((1/d) * 2^16) as (65536 + d/2) / d; entry 0 is never used
    localparam logic [WGT_W-1:0] WEIGHT_LUT [64] = '{
        17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923, 17'd9362,
        17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
        17'd4096,  17'd3855,  17'd3641,  17'd3449,  17'd3277,  17'd3121,  17'd2979,  17'd2849,
        17'd2731,  17'd2621,  17'd2521,  17'd2427,  17'd2341,  17'd2260,  17'd2185,  17'd2114,
        17'd2048,  17'd1986,  17'd1928,  17'd1872,  17'd1820,  17'd1771,  17'd1725,  17'd1680,
        17'd1638,  17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1425,  17'd1394,
        17'd1365,  17'd1337,  17'd1311,  17'd1285,  17'd1260,  17'd1237,  17'd1214,  17'd1192,
        17'd1170,  17'd1150,  17'd1130,  17'd1111,  17'd1092,  17'd1074,  17'd1057,  17'd1040
    };

endpackage

// ----- rtl/vam_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module vam_ram #(
    parameter int WIDTH = 70,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/vam_row_merge.sv -----
// Merges the two other triangle corners into one adjacency row and updates its degree.
module vam_row_merge
    import vam_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  corner_sel_t                         sel,
    input  logic [MAX_VERTICES-1:0]             old_bits,
    input  logic [$clog2(MAX_VERTICES)-1:0]     old_deg,
    output logic [MAX_VERTICES-1:0]             new_bits,
    output logic [$clog2(MAX_VERTICES)-1:0]     new_deg
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES);

    logic                    p_ok, q_ok, add_p, add_q;
    logic [MAX_VERTICES-1:0] one, p_mask, q_mask;

    assign one  = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    assign p_ok = (sel.peer_p != sel.self_idx);
    // a repeated peer is counted once
    assign q_ok = (sel.peer_q != sel.self_idx) && (sel.peer_q != sel.peer_p);

    assign p_mask = p_ok ? (one << sel.peer_p[AW-1:0]) : '0;
    assign q_mask = q_ok ? (one << sel.peer_q[AW-1:0]) : '0;

    assign add_p = p_ok & ~old_bits[sel.peer_p[AW-1:0]];
    assign add_q = q_ok & ~old_bits[sel.peer_q[AW-1:0]];

    assign new_bits = old_bits | p_mask | q_mask;
    assign new_deg  = old_deg + DW'(add_p) + DW'(add_q);

endmodule

// ----- rtl/vertex_adjacency_laplacian_builder.sv -----
// Uniform vertex Laplacian builder: adjacency rows in RAM, one neighbor per result.
//
// Each adjacency row lives in one RAM word together with its degree, so no bit
// count is needed at read time. Add triangle does three read-modify-writes, one
// per corner, on the single RAM port, then the response. A row read does one RAM
// read, one load of the row into the scan register, then one neighbor per cycle
// from a lowest-set-bit scan while the result side does not stall (or one empty
// result). Clear, an unused code and any rejected item give only the response.
// A stalled result holds back the next one. Each row has a valid flop, so reset
// and clear take effect at once, with no clearing pass. One item is in work at a
// time; a finished result waits in the output register while the block is free
// to accept the next item. The vertex count register is to be written only while
// the block is idle; the block itself does not enforce it.
module vertex_adjacency_laplacian_builder
    import vam_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [IDX_W-1:0]  vert_a,
    input  logic [IDX_W-1:0]  vert_b,
    input  logic [IDX_W-1:0]  vert_c,
    input  logic [IDX_W-1:0]  row_index,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [STS_W-1:0]  status,
    output logic              has_entry,
    output logic [IDX_W-1:0]  neighbor,
    output logic [IDX_W-1:0]  degree,
    output logic [WGT_W-1:0]  weight,
    output logic              last
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int DW    = $clog2(MAX_VERTICES);
    localparam int ENT_W = MAX_VERTICES + DW;
    localparam logic [CNT_W-1:0] MAX_LIM = CNT_W'(MAX_VERTICES);

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    // control state
    state_t                  state_reg, state_next;
    logic [1:0]              corner_reg, corner_next;
    logic                    err_reg, err_next;
    logic [MAX_VERTICES-1:0] valid_reg, valid_next;
    logic                    rdv_reg, rdv_next;
    logic [CNT_W-1:0]        vc_reg, vc_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    range_reg, range_next;

    // payload
    logic [IDX_W-1:0]        a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [IDX_W-1:0]        row_reg, row_next;
    logic [MAX_VERTICES-1:0] scan_reg, scan_next;
    logic [DW-1:0]           deg_reg, deg_next;
    logic [STS_W-1:0]        status_reg, status_next;
    logic                    has_entry_reg, has_entry_next;
    logic [IDX_W-1:0]        neighbor_reg, neighbor_next;
    logic [IDX_W-1:0]        degree_reg, degree_next;
    logic [WGT_W-1:0]        weight_reg, weight_next;
    logic                    last_reg, last_next;

    logic [CNT_W-1:0]        lim;
    logic                    tri_bad, row_bad, out_free;
    corner_sel_t             sel;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [ENT_W-1:0]        ram_wdata, ram_rdata, ent;
    logic [MAX_VERTICES-1:0] merged_bits;
    logic [DW-1:0]           merged_deg;
    logic [MAX_VERTICES-1:0] low_bit, scan_rem;
    logic [IDX_W-1:0]        nb_idx;

    assign lim     = (vc_reg > MAX_LIM) ? MAX_LIM : vc_reg;
    assign tri_bad = ({1'b0, vert_a} >= lim) || ({1'b0, vert_b} >= lim)
                  || ({1'b0, vert_c} >= lim);
    assign row_bad = ({1'b0, row_index} >= lim);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (corner_reg)
            CORNER_B: sel = '{self_idx: b_reg, peer_p: c_reg, peer_q: a_reg};
            CORNER_C: sel = '{self_idx: c_reg, peer_p: a_reg, peer_q: b_reg};
            default:  sel = '{self_idx: a_reg, peer_p: b_reg, peer_q: c_reg};
        endcase
    end

    // a row never written since reset or clear reads as empty
    assign ent = rdv_reg ? ram_rdata : '0;

    vam_row_merge #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_merge (
        .sel      (sel),
        .old_bits (ent[MAX_VERTICES-1:0]),
        .old_deg  (ent[ENT_W-1:MAX_VERTICES]),
        .new_bits (merged_bits),
        .new_deg  (merged_deg)
    );

    vam_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {merged_deg, merged_bits};

    // lowest remaining neighbor and the row with it removed
    assign low_bit  = scan_reg & (~scan_reg + MAX_VERTICES'(1));
    assign scan_rem = scan_reg & (scan_reg - MAX_VERTICES'(1));

    always_comb
    begin
        nb_idx = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (low_bit[i])
            begin
                nb_idx = nb_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        err_next       = err_reg;
        valid_next     = valid_reg;
        rdv_next       = rdv_reg;
        vc_next        = cfg_wr_en ? cfg_wr_data : vc_reg;
        out_valid_next = out_valid_reg && out_stall;
        range_next     = range_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        row_next       = row_reg;
        scan_next      = scan_reg;
        deg_next       = deg_reg;
        status_next    = status_reg;
        has_entry_next = has_entry_reg;
        neighbor_next  = neighbor_reg;
        degree_next    = degree_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = sel.self_idx[AW-1:0];
        ram_raddr      = sel.self_idx[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = vert_a;
                    b_next     = vert_b;
                    c_next     = vert_c;
                    row_next   = row_index;
                    range_next = 1'b0;
                    case (req_t'(req_type))
                        REQ_ADD:
                        begin
                            if (tri_bad)
                            begin
                                err_next   = 1'b1;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                corner_next = CORNER_A;
                                state_next  = S_RD;
                            end
                        end
                        REQ_READ:
                        begin
                            if (row_bad)
                            begin
                                range_next = 1'b1;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ROWRD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            valid_next = '0;
                            err_next   = 1'b0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                rdv_next   = valid_reg[sel.self_idx[AW-1:0]];
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we = 1'b1;
                valid_next[sel.self_idx[AW-1:0]] = 1'b1;
                if (corner_reg == CORNER_C)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = S_RD;
                end
            end
            S_ROWRD:
            begin
                ram_raddr  = row_reg[AW-1:0];
                rdv_next   = valid_reg[row_reg[AW-1:0]];
                state_next = S_ROWLD;
            end
            S_ROWLD:
            begin
                scan_next  = ent[MAX_VERTICES-1:0];
                deg_next   = ent[ENT_W-1:MAX_VERTICES];
                state_next = (ent[ENT_W-1:MAX_VERTICES] == '0) ? S_RESP : S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = err_reg ? ST_INDEX_ERR : ST_OK;
                    has_entry_next = 1'b1;
                    neighbor_next  = nb_idx;
                    degree_next    = IDX_W'(deg_reg);
                    weight_next    = WEIGHT_LUT[IDX_W'(deg_reg)];
                    last_next      = (scan_rem == '0);
                    scan_next      = scan_rem;
                    if (scan_rem == '0)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = range_reg ? ST_ROW_RANGE
                                   : (err_reg ? ST_INDEX_ERR : ST_OK);
                    has_entry_next = 1'b0;
                    neighbor_next  = '0;
                    degree_next    = '0;
                    weight_next    = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            corner_reg    <= CORNER_A;
            err_reg       <= 1'b0;
            valid_reg     <= '0;
            rdv_reg       <= 1'b0;
            vc_reg        <= 7'd64;
            out_valid_reg <= 1'b0;
            range_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            err_reg       <= err_next;
            valid_reg     <= valid_next;
            rdv_reg       <= rdv_next;
            vc_reg        <= vc_next;
            out_valid_reg <= out_valid_next;
            range_reg     <= range_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        row_reg       <= row_next;
        scan_reg      <= scan_next;
        deg_reg       <= deg_next;
        status_reg    <= status_next;
        has_entry_reg <= has_entry_next;
        neighbor_reg  <= neighbor_next;
        degree_reg    <= degree_next;
        weight_reg    <= weight_next;
        last_reg      <= last_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign has_entry = has_entry_reg;
    assign neighbor  = neighbor_reg;
    assign degree    = degree_reg;
    assign weight    = weight_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_entry_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_entry |-> degree != '0 && weight != '0)
        else $error("matrix entry with zero degree or weight");

    a_range_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ROW_RANGE |-> !has_entry && last)
        else $error("row range error is not a single empty result");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> scan_reg != '0)
        else $error("emitting from an empty row");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |-> state_reg == S_EMIT)
        else $error("non-final result taken while row is not being emitted");

    a_write_corner: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> corner_reg == CORNER_A || corner_reg == CORNER_B
                || corner_reg == CORNER_C)
        else $error("row write with no corner selected");
`endif

endmodule
